/* hw/rtl/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared types and constants for the two-heap running median.
// ----------------------------------------------------------------------------
`default_nettype none

package rmh_pkg;

  localparam int HeapDepth  = 1024;
  localparam int SampleBits = 16;
  localparam int AddrBits   = $clog2(HeapDepth);
  localparam int CountBits  = AddrBits + 1;
  localparam int MedBits    = SampleBits + 1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [AddrBits-1:0]          addr_t;
  typedef logic [CountBits-1:0]         count_t;

  // Command from the sequencer to one heap unit.
  typedef struct packed {
    logic    push;
    logic    pop;
    sample_t value;
  } heap_cmd_t;

  // Status of one heap unit.
  typedef struct packed {
    logic    busy;
    count_t  count;
    sample_t top;
    sample_t popped;
  } heap_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/rmh_heap.sv */
// ----------------------------------------------------------------------------
// rmh_heap
// One binary heap in a synchronous RAM with a sift-up/sift-down walker.
// ----------------------------------------------------------------------------
`default_nettype none

module rmh_heap
  import rmh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       is_max_i,
  input  wire logic       clear_i,
  input  wire heap_cmd_t  cmd_i,
  output heap_stat_t      stat_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPRD  = 8'b0000_0010,
    S_UPCMP = 8'b0000_0100,
    S_DNRDL = 8'b0000_1000,
    S_DNRDR = 8'b0001_0000,
    S_DNL   = 8'b0010_0000,
    S_DNCMP = 8'b0100_0000,
    S_POPRD = 8'b1000_0000
  } state_e;

  sample_t mem [HeapDepth];
  sample_t rdata_q;
  addr_t   raddr;
  logic    we;
  addr_t   waddr;
  sample_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  state_e  state_q, state_d;
  count_t  count_q, count_d;
  addr_t   idx_q, idx_d;
  sample_t val_q, val_d;
  sample_t top_q, top_d;
  sample_t pop_q, pop_d;
  sample_t lv_q, lv_d;
  logic    rsel_q, rsel_d;

  function automatic logic above(input logic mx, input sample_t a, input sample_t b);
    above = mx ? (a > b) : (a < b);
  endfunction

  count_t l_c, r_c;
  assign l_c = {idx_q, 1'b1};
  assign r_c = {idx_q, 1'b0} + count_t'(2);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    val_d   = val_q;
    top_d   = top_q;
    pop_d   = pop_q;
    lv_d    = lv_q;
    raddr   = '0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = val_q;
    case (state_q)
      S_IDLE: begin
        if (clear_i) begin
          count_d = '0;
        end else if (cmd_i.push) begin
          idx_d   = addr_t'(count_q);
          val_d   = cmd_i.value;
          count_d = count_q + count_t'(1);
          if (count_q == '0) begin
            we = 1'b1; waddr = '0; wdata = cmd_i.value; top_d = cmd_i.value;
          end else begin
            raddr   = addr_t'((count_q - count_t'(1)) >> 1);
            state_d = S_UPCMP;
          end
        end else if (cmd_i.pop) begin
          pop_d   = top_q;
          count_d = count_q - count_t'(1);
          raddr   = addr_t'(count_q - count_t'(1));
          idx_d   = '0;
          state_d = S_POPRD;
        end
      end
      S_UPCMP: begin
        if (above(is_max_i, val_q, rdata_q)) begin
          we = 1'b1; waddr = idx_q; wdata = rdata_q;
          idx_d = addr_t'((idx_q - addr_t'(1)) >> 1);
          if (idx_d == '0) begin
            state_d = S_UPRD;
          end else begin
            raddr = addr_t'((idx_d - addr_t'(1)) >> 1);
          end
        end else begin
          state_d = S_UPRD;
        end
      end
      S_UPRD: begin
        we = 1'b1; waddr = idx_q; wdata = val_q;
        if (idx_q == '0) top_d = val_q;
        state_d = S_IDLE;
      end
      S_POPRD: begin
        val_d = rdata_q;
        if (count_q == '0) begin
          state_d = S_IDLE;
        end else begin
          top_d = rdata_q;
          state_d = S_DNRDL;
        end
      end
      S_DNRDL: begin
        if (l_c < count_q) begin
          raddr   = addr_t'(l_c);
          state_d = S_DNL;
        end else begin
          state_d = S_UPRD;
        end
      end
      S_DNL: begin
        lv_d = rdata_q;
        if (r_c < count_q) begin
          raddr   = addr_t'(r_c);
          state_d = S_DNRDR;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNRDR: begin
        if (above(is_max_i, rdata_q, lv_q)) begin
          lv_d = rdata_q; idx_d = idx_q;
          state_d = S_DNCMP;
          pop_d = pop_q;
          val_d = val_q;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (above(is_max_i, lv_q, val_q)) begin
          we = 1'b1; waddr = idx_q; wdata = lv_q;
          if (idx_q == '0) top_d = lv_q;
          idx_d   = addr_t'(rsel_q ? r_c : l_c);
          state_d = S_DNRDL;
        end else begin
          state_d = S_UPRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsel_d = rsel_q;
    if (state_q == S_DNL) rsel_d = 1'b0;
    if (state_q == S_DNRDR) rsel_d = above(is_max_i, rdata_q, lv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    top_q  <= top_d;
    pop_q  <= pop_d;
    lv_q   <= lv_d;
    rsel_q <= rsel_d;
  end

  assign stat_o.busy   = (state_q != S_IDLE);
  assign stat_o.count  = count_q;
  assign stat_o.top    = top_q;
  assign stat_o.popped = pop_q;

endmodule

`default_nettype wire

/* hw/rtl/running_median_two_heaps.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of a signed sample stream kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample_i, last_sample_i with valid_i / stall_o.
//   Output channel: median_doubled_o, dropped_o with valid_o / stall_i.
//   One result per transaction, twice the median (low top + high top, or
//   twice the low top when the low heap holds one more sample).
//   One sample at a time: insertion sift-up, then an optional pop with
//   sift-down and a push into the other heap. Sift-up and sift-down walk
//   the heap one level at a time through heap RAM reads, and each heap
//   holds up to 1024 entries.
//   A sample for a full heap is dropped and flagged.
//   last_sample_i empties both heaps after its result is formed.
//   Reset empties both heaps at once; no clearing pass.
//   The result sits in an output register; while stall_i is high the
//   result holds and a new sample is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps
  import rmh_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       stall_o,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic                  last_sample_i,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output logic [MedBits-1:0]         median_doubled_o,
  output logic                       dropped_o
);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_INS  = 6'b000010,
    M_BAL  = 6'b000100,
    M_MOVE = 6'b001000,
    M_FIN  = 6'b010000,
    M_OUT  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  heap_cmd_t  lo_cmd, hi_cmd;
  heap_stat_t lo_st, hi_st;
  logic       clear;
  logic       last_q, last_d;
  logic       lo2hi_q, lo2hi_d;
  logic       drop_q, drop_d;
  logic       valid_q, valid_d;
  logic [MedBits-1:0] med_q, med_d;

  rmh_heap u_low  (.clk_i, .rst_ni, .is_max_i(1'b1), .clear_i(clear),
                   .cmd_i(lo_cmd), .stat_o(lo_st));
  rmh_heap u_high (.clk_i, .rst_ni, .is_max_i(1'b0), .clear_i(clear),
                   .cmd_i(hi_cmd), .stat_o(hi_st));

  logic busy;
  logic to_low;
  assign busy   = lo_st.busy | hi_st.busy;
  assign to_low = (lo_st.count == '0) || ($signed(sample_i) <= lo_st.top);
  assign stall_o = (state_q != M_IDLE) || valid_q;

  always_comb begin
    state_d = state_q;
    lo_cmd  = '0;
    hi_cmd  = '0;
    clear   = 1'b0;
    last_d  = last_q;
    lo2hi_d = lo2hi_q;
    drop_d  = drop_q;
    valid_d = valid_q;
    med_d   = med_q;
    if (valid_q && !stall_i) valid_d = 1'b0;
    case (state_q)
      M_IDLE: begin
        if (valid_i && !stall_o) begin
          last_d = last_sample_i;
          drop_d = 1'b0;
          if (to_low) begin
            if (lo_st.count == count_t'(HeapDepth)) drop_d = 1'b1;
            else begin lo_cmd.push = 1'b1; lo_cmd.value = sample_i; end
          end else begin
            if (hi_st.count == count_t'(HeapDepth)) drop_d = 1'b1;
            else begin hi_cmd.push = 1'b1; hi_cmd.value = sample_i; end
          end
          state_d = M_INS;
        end
      end
      M_INS: begin
        if (!busy) begin
          if (drop_q) state_d = M_FIN;
          else if (lo_st.count > hi_st.count + count_t'(1)) begin
            lo_cmd.pop = 1'b1; lo2hi_d = 1'b1; state_d = M_BAL;
          end else if (hi_st.count > lo_st.count) begin
            hi_cmd.pop = 1'b1; lo2hi_d = 1'b0; state_d = M_BAL;
          end else state_d = M_FIN;
        end
      end
      M_BAL: begin
        if (!busy) begin
          if (lo2hi_q) begin hi_cmd.push = 1'b1; hi_cmd.value = lo_st.popped; end
          else begin lo_cmd.push = 1'b1; lo_cmd.value = hi_st.popped; end
          state_d = M_MOVE;
        end
      end
      M_MOVE: begin
        if (!busy) state_d = M_FIN;
      end
      M_FIN: begin
        if (lo_st.count == '0) med_d = '0;
        else if (lo_st.count == hi_st.count)
          med_d = MedBits'({lo_st.top[SampleBits-1], lo_st.top}
                         + {hi_st.top[SampleBits-1], hi_st.top});
        else med_d = {lo_st.top, 1'b0};
        valid_d = 1'b1;
        clear   = last_q;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    lo2hi_q <= lo2hi_d;
    drop_q  <= drop_d;
    med_q   <= med_d;
  end

  assign valid_o          = valid_q;
  assign median_doubled_o = med_q;
  assign dropped_o        = drop_q;

endmodule

`default_nettype wire

/* hw/rtl/rmh_checker.sv */
// ----------------------------------------------------------------------------
// rmh_checker
// Port-level checks for the running median block.
// ----------------------------------------------------------------------------
`default_nettype none

module rmh_port_checks
  import rmh_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               valid_i,
  input wire logic               stall_o,
  input wire logic               valid_o,
  input wire logic               stall_i,
  input wire logic [MedBits-1:0] median_doubled_o,
  input wire logic               dropped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(median_doubled_o) && $stable(dropped_o))
    else $error("result changed while stalled");

  a_busy_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input open while result pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("second sample taken without work");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown({median_doubled_o, dropped_o}))
    else $error("result carries unknown bits");

endmodule

bind running_median_two_heaps rmh_port_checks u_rmh_port_checks (.*);

`default_nettype wire
